>>> rtl/av_startup_window_search_top_assert.svh
// assertion macros for the startup window search
`ifndef AV_STARTUP_WINDOW_SEARCH_TOP_ASSERT_SVH
`define AV_STARTUP_WINDOW_SEARCH_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define AVS_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define AVS_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/avsws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsws_pkg
// shared types and codes of the startup window search
// ----------------------------------------------------------------------------
package avsws_pkg;
    localparam logic [1:0] OP_LOAD_VIDEO = 2'd0;
    localparam logic [1:0] OP_LOAD_AUDIO = 2'd1;
    localparam logic [1:0] OP_RUN        = 2'd2;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_ARITH    = 2'd2;
    localparam logic [1:0] ST_CAPACITY = 2'd3;

    localparam int CFG_KEY   = 0;
    localparam int CFG_TRIM  = 1;
    localparam int CFG_SKEW  = 2;
    localparam int CFG_PRE   = 3;
    localparam int CFG_MTRIM = 4;

    localparam int STEP_BITS = 10;

    // controller to datapath commands
    typedef struct packed {
        logic clear_steps;
        logic rd_video;    // issue read of video entry at vi
        logic rd_audio;    // issue read of audio entry at ac
        logic eval_video;  // compute video bounds
        logic eval_audio;  // not read by the datapath; audio terms are combinational
        logic step;        // count one examination
        logic inc_vi;
        logic inc_ac;
        logic take;        // latch found pair
    } avsws_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic v_more;      // vi below video count
        logic a_more;      // ac below audio count
        logic v_skip;      // key frame needed but absent
        logic v_ovf;
        logic v_short;     // video cover below vneed
        logic a_below;     // audio start below lo
        logic a_above;     // audio start above hi
        logic a_ovf;
        logic a_skip;      // advance audio
        logic a_break;     // video cover below need
        logic a_hit;
    } avsws_sts_t;
endpackage

>>> rtl/avsws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsws_datapath
// unit stores, pointers, time arithmetic and the step counter
// ----------------------------------------------------------------------------
module avsws_datapath
    import avsws_pkg::*;
#(
    parameter int MAX_VIDEO_UNITS = 256,
    parameter int MAX_AUDIO_UNITS = 256,
    parameter int TIME_BITS       = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ld_video,
    input  logic                 ld_audio,
    input  logic                 run_done,   // clears counts
    input  logic [TIME_BITS-1:0] in_start,
    input  logic [TIME_BITS-2:0] in_dur,
    input  logic [TIME_BITS-1:0] in_cover,
    input  logic                 in_key,
    input  logic                 cfg_key,
    input  logic                 cfg_trim,
    input  logic [TIME_BITS-2:0] cfg_skew,
    input  logic [TIME_BITS-2:0] cfg_pre,
    input  logic [TIME_BITS-2:0] cfg_mtrim,
    input  avsws_cmd_t           cmd,
    output avsws_sts_t           sts,
    output logic                 lost,
    output logic [7:0]           vslot,
    output logic [7:0]           aslot,
    output logic [TIME_BITS-1:0] wstart,
    output logic [STEP_BITS-1:0] steps
);
    localparam int VA = (MAX_VIDEO_UNITS > 1) ? $clog2(MAX_VIDEO_UNITS) : 1;
    localparam int AA = (MAX_AUDIO_UNITS > 1) ? $clog2(MAX_AUDIO_UNITS) : 1;
    localparam int VC = $clog2(MAX_VIDEO_UNITS + 1);
    localparam int AC = $clog2(MAX_AUDIO_UNITS + 1);
    localparam int W  = TIME_BITS + 2;

    logic [TIME_BITS-1:0] vst_mem [MAX_VIDEO_UNITS];
    logic [TIME_BITS-1:0] vcv_mem [MAX_VIDEO_UNITS];
    logic                 vky_mem [MAX_VIDEO_UNITS];
    logic [TIME_BITS-1:0] ast_mem [MAX_AUDIO_UNITS];
    logic [TIME_BITS-2:0] adu_mem [MAX_AUDIO_UNITS];
    logic [TIME_BITS-1:0] acv_mem [MAX_AUDIO_UNITS];

    logic [VC-1:0] vcnt_reg, vi_reg;
    logic [AC-1:0] acnt_reg, ac_reg;
    logic          lost_reg;
    logic [STEP_BITS-1:0] steps_reg;

    logic [TIME_BITS-1:0] vst_q, vcv_q, ast_q, acv_q;
    logic [TIME_BITS-2:0] adu_q;
    logic                 vky_q;

    logic signed [W-1:0] lo_reg, hi_reg, vneed_reg, vcov_reg, vst_reg;
    logic                v_ovf_reg;

    logic signed [W-1:0] a_s, src_s, aend_s, need_s, trim_s, tmin, tmax;
    logic                a_ovf_c;
    logic                a_early_skip, a_trim_ovf;
    logic [7:0]           vslot_reg, aslot_reg;
    logic [TIME_BITS-1:0] ws_reg;

    assign tmax = W'(signed'({1'b0, {(TIME_BITS-1){1'b1}}}));
    assign tmin = -tmax - W'(1);

    // store writes
    always_ff @(posedge aclk) begin
        if (ld_video && (vcnt_reg < VC'(MAX_VIDEO_UNITS))) begin
            vst_mem[vcnt_reg[VA-1:0]] <= in_start;
            vcv_mem[vcnt_reg[VA-1:0]] <= in_cover;
            vky_mem[vcnt_reg[VA-1:0]] <= in_key;
        end
        if (ld_audio && (acnt_reg < AC'(MAX_AUDIO_UNITS))) begin
            ast_mem[acnt_reg[AA-1:0]] <= in_start;
            adu_mem[acnt_reg[AA-1:0]] <= in_dur;
            acv_mem[acnt_reg[AA-1:0]] <= in_cover;
        end
    end

    // registered store reads
    always_ff @(posedge aclk) begin
        if (cmd.rd_video) begin
            vst_q <= vst_mem[vi_reg[VA-1:0]];
            vcv_q <= vcv_mem[vi_reg[VA-1:0]];
            vky_q <= vky_mem[vi_reg[VA-1:0]];
        end
        if (cmd.rd_audio) begin
            ast_q <= ast_mem[ac_reg[AA-1:0]];
            adu_q <= adu_mem[ac_reg[AA-1:0]];
            acv_q <= acv_mem[ac_reg[AA-1:0]];
        end
    end

    // counts, pointers and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg  <= '0;
            acnt_reg  <= '0;
            lost_reg  <= 1'b0;
            vi_reg    <= '0;
            ac_reg    <= '0;
            steps_reg <= '0;
        end else begin
            if (ld_video) begin
                if (vcnt_reg < VC'(MAX_VIDEO_UNITS)) vcnt_reg <= vcnt_reg + VC'(1);
                else lost_reg <= 1'b1;
            end
            if (ld_audio) begin
                if (acnt_reg < AC'(MAX_AUDIO_UNITS)) acnt_reg <= acnt_reg + AC'(1);
                else lost_reg <= 1'b1;
            end
            if (run_done) begin
                vcnt_reg <= '0;
                acnt_reg <= '0;
                lost_reg <= 1'b0;
            end
            if (cmd.clear_steps) begin
                steps_reg <= '0;
                vi_reg    <= '0;
                ac_reg    <= '0;
            end else begin
                if (cmd.step && steps_reg != '1) steps_reg <= steps_reg + STEP_BITS'(1);
                if (cmd.inc_vi) vi_reg <= vi_reg + VC'(1);
                if (cmd.inc_ac) ac_reg <= ac_reg + AC'(1);
            end
        end
    end

    // video bounds, one add each
    always_ff @(posedge aclk) begin
        if (cmd.eval_video) begin
            vst_reg   <= W'(signed'(vst_q));
            vcov_reg  <= W'(signed'(vcv_q));
            lo_reg    <= W'(signed'(vst_q)) - W'(cfg_skew);
            hi_reg    <= W'(signed'(vst_q)) + W'(cfg_skew);
            vneed_reg <= W'(signed'(vst_q)) + W'(cfg_pre);
        end
    end

    always_comb begin
        v_ovf_reg = (lo_reg < tmin) || (hi_reg > tmax) || (vneed_reg > tmax);
    end

    // audio terms; with trim off, an early audio start is passed over before
    // any range check; the trim range only counts once the audio end lies past the start
    always_comb begin
        a_s    = W'(signed'(ast_q));
        src_s  = (cfg_trim && a_s > vst_reg) ? a_s : vst_reg;
        aend_s = a_s + W'(adu_q);
        need_s = src_s + W'(cfg_pre);
        trim_s = src_s - a_s;
        a_early_skip = !cfg_trim && a_s < vst_reg;
        a_trim_ovf   = cfg_trim && (trim_s > tmax);
        a_ovf_c = !a_early_skip && ((aend_s > tmax) || (need_s > tmax)
                  || (!(aend_s <= src_s) && a_trim_ovf));
    end

    assign sts.v_more  = vi_reg < vcnt_reg;
    assign sts.a_more  = ac_reg < acnt_reg;
    assign sts.v_skip  = cfg_key && !vky_q;
    assign sts.v_ovf   = v_ovf_reg;
    assign sts.v_short = vcov_reg < vneed_reg;
    assign sts.a_below = a_s < lo_reg;
    assign sts.a_above = a_s > hi_reg;
    assign sts.a_ovf   = a_ovf_c;
    assign sts.a_skip  = a_early_skip || (aend_s <= src_s)
                       || (cfg_trim && trim_s > W'(cfg_mtrim));
    assign sts.a_break = vcov_reg < need_s;
    assign sts.a_hit   = W'(signed'(acv_q)) >= need_s;

    // result capture
    always_ff @(posedge aclk) begin
        if (cmd.clear_steps) begin
            vslot_reg <= '0;
            aslot_reg <= '0;
            ws_reg    <= '0;
        end else if (cmd.take) begin
            vslot_reg <= 8'(vi_reg);
            aslot_reg <= 8'(ac_reg);
            ws_reg    <= src_s[TIME_BITS-1:0];
        end
    end

    assign lost   = lost_reg;
    assign vslot  = vslot_reg;
    assign aslot  = aslot_reg;
    assign wstart = ws_reg;
    assign steps  = steps_reg;
endmodule

>>> rtl/avsws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avsws_ctrl
// search sequencer and result handshake
// ----------------------------------------------------------------------------
module avsws_ctrl
    import avsws_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       run_start,
    input  logic       lost,
    input  avsws_sts_t sts,
    input  logic       out_take,
    output avsws_cmd_t cmd,
    output logic       busy,
    output logic       run_done,
    output logic       out_valid,
    output logic [1:0] out_status
);
`include "av_startup_window_search_top_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_VRD  = 3'd1;
    localparam logic [2:0] S_VEV  = 3'd2;
    localparam logic [2:0] S_VCK  = 3'd3;
    localparam logic [2:0] S_ARD  = 3'd4;
    localparam logic [2:0] S_ACK  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] status_reg, status_next;
    logic       phase_reg, phase_next;   // 0 skip below lo, 1 window walk

    // next state logic
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        phase_next  = phase_reg;
        cmd         = '0;
        run_done    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (run_start) begin
                    cmd.clear_steps = 1'b1;
                    if (lost) begin
                        status_next = ST_CAPACITY;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_VRD;
                    end
                end
            end
            S_VRD: begin
                if (sts.v_more) begin
                    cmd.rd_video = 1'b1;
                    cmd.step     = 1'b1;
                    state_next   = S_VEV;
                end else begin
                    status_next = ST_NONE;
                    state_next  = S_OUT;
                end
            end
            S_VEV: begin
                if (sts.v_skip) begin
                    cmd.inc_vi = 1'b1;
                    state_next = S_VRD;
                end else begin
                    cmd.eval_video = 1'b1;
                    state_next     = S_VCK;
                end
            end
            S_VCK: begin
                if (sts.v_ovf) begin
                    status_next = ST_ARITH;
                    state_next  = S_OUT;
                end else if (sts.v_short) begin
                    cmd.inc_vi = 1'b1;
                    state_next = S_VRD;
                end else begin
                    phase_next = 1'b0;
                    state_next = S_ARD;
                end
            end
            S_ARD: begin
                if (sts.a_more) begin
                    cmd.rd_audio = 1'b1;
                    state_next   = S_ACK;
                end else begin
                    cmd.inc_vi = 1'b1;
                    state_next = S_VRD;
                end
            end
            S_ACK: begin
                if (!phase_reg && sts.a_below) begin
                    cmd.step   = 1'b1;
                    cmd.inc_ac = 1'b1;
                    state_next = S_ARD;
                end else if (sts.a_above) begin
                    cmd.inc_vi = 1'b1;
                    state_next = S_VRD;
                end else begin
                    phase_next = 1'b1;
                    cmd.step   = 1'b1;
                    if (sts.a_ovf) begin
                        status_next = ST_ARITH;
                        state_next  = S_OUT;
                    end else if (sts.a_skip) begin
                        cmd.inc_ac = 1'b1;
                        state_next = S_ARD;
                    end else if (sts.a_break) begin
                        cmd.inc_vi = 1'b1;
                        state_next = S_VRD;
                    end else if (sts.a_hit) begin
                        cmd.take    = 1'b1;
                        status_next = ST_FOUND;
                        state_next  = S_OUT;
                    end else begin
                        cmd.inc_ac = 1'b1;
                        state_next = S_ARD;
                    end
                end
            end
            S_OUT: begin
                if (out_take) begin
                    run_done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_NONE;
            phase_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            phase_reg  <= phase_next;
        end
    end

    assign busy       = state_reg != S_IDLE;
    assign out_valid  = state_reg == S_OUT;
    assign out_status = status_reg;

    // checks
    `AVS_ASSERT_NEXT(a_run_leaves_idle, aclk, aresetn, run_start && !busy, busy)
    `AVS_ASSERT_IMP(a_take_only_walk, aclk, aresetn, cmd.take, state_reg == S_ACK)
    `AVS_ASSERT_NEXT(a_done_idle, aclk, aresetn, run_done, !busy)
    `AVS_ASSERT_IMP(a_cap_status, aclk, aresetn,
        run_start && !busy && lost, state_next == S_OUT && status_next == ST_CAPACITY)
endmodule

>>> rtl/av_startup_window_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av_startup_window_search_top
// loads video and audio units and searches the first startup window
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (lsb first)
// s_      | in  | start_time, unit_duration, coverage_end, key_frame; tuser operation
// m_      | out | video_slot, audio_slot, window_start, step_count; tuser status
// apb     | in  | five registers at 8*i
// a new word is taken every cycle while no run is busy
// each store has one registered read port, followed by a compare stage
// no word is taken from a run until its result is taken on m_
// reset is synchronous; stores have no clearing pass
// ----------------------------------------------------------------------------
module av_startup_window_search_top
    import avsws_pkg::*;
#(
    parameter int MAX_VIDEO_UNITS = 256,
    parameter int MAX_AUDIO_UNITS = 256,
    parameter int TIME_BITS       = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_time, unit_duration, coverage_end, key_frame
    input  logic [((3*TIME_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // video_slot, audio_slot, window_start, step_count
    output logic [((TIME_BITS+26+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int MW = ((TIME_BITS+26+7)/8)*8;

    logic                 key_reg, trim_reg;
    logic [TIME_BITS-2:0] skew_reg, pre_reg, mtrim_reg;
    logic                 wr;
    logic [2:0]           ridx;

    avsws_cmd_t cmd;
    avsws_sts_t sts;
    logic       busy, run_done, lost, ld_v, ld_a, run_start, acc;
    logic [1:0] status;
    logic [7:0] vslot, aslot;
    logic [TIME_BITS-1:0] wstart;
    logic [STEP_BITS-1:0] steps;

    // register port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[5:3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= 1'b1;
            trim_reg  <= 1'b0;
            skew_reg  <= '0;
            pre_reg   <= '0;
            mtrim_reg <= '0;
        end else if (wr) begin
            case (ridx)
                3'(CFG_KEY):   key_reg   <= pwdata[0];
                3'(CFG_TRIM):  trim_reg  <= pwdata[0];
                3'(CFG_SKEW):  skew_reg  <= pwdata[TIME_BITS-2:0];
                3'(CFG_PRE):   pre_reg   <= pwdata[TIME_BITS-2:0];
                3'(CFG_MTRIM): mtrim_reg <= pwdata[TIME_BITS-2:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (ridx)
            3'(CFG_KEY):   prdata = 64'(key_reg);
            3'(CFG_TRIM):  prdata = 64'(trim_reg);
            3'(CFG_SKEW):  prdata = 64'(skew_reg);
            3'(CFG_PRE):   prdata = 64'(pre_reg);
            3'(CFG_MTRIM): prdata = 64'(mtrim_reg);
            default:       prdata = '0;
        endcase
    end

    // input word decode
    assign s_tready  = !busy;
    assign acc       = s_tvalid && s_tready;
    assign ld_v      = acc && s_tuser == OP_LOAD_VIDEO;
    assign ld_a      = acc && s_tuser == OP_LOAD_AUDIO;
    assign run_start = acc && s_tuser == OP_RUN;

    avsws_datapath #(
        .MAX_VIDEO_UNITS(MAX_VIDEO_UNITS),
        .MAX_AUDIO_UNITS(MAX_AUDIO_UNITS),
        .TIME_BITS(TIME_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .ld_video(ld_v), .ld_audio(ld_a), .run_done(run_done),
        .in_start(s_tdata[TIME_BITS-1:0]),
        .in_dur(s_tdata[2*TIME_BITS-2:TIME_BITS]),
        .in_cover(s_tdata[3*TIME_BITS-2:2*TIME_BITS-1]),
        .in_key(s_tdata[3*TIME_BITS-1]),
        .cfg_key(key_reg), .cfg_trim(trim_reg), .cfg_skew(skew_reg),
        .cfg_pre(pre_reg), .cfg_mtrim(mtrim_reg),
        .cmd(cmd), .sts(sts), .lost(lost),
        .vslot(vslot), .aslot(aslot), .wstart(wstart), .steps(steps)
    );

    avsws_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .run_start(run_start), .lost(lost), .sts(sts),
        .out_take(m_tready), .cmd(cmd), .busy(busy), .run_done(run_done),
        .out_valid(m_tvalid), .out_status(status)
    );

    assign m_tuser = status;
    assign m_tdata = MW'({steps, wstart, aslot, vslot});

    // address and data bits outside the register map
    logic unused_pad;
    assign unused_pad = ^paddr[2:0] | ^pwdata[63:TIME_BITS-1];
endmodule

>>> bench/tb_av_startup_window_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_av_startup_window_search_top
// self-checking bench for the audio/video startup window search: a directed
// table (empty run, found pair, overflow, field extremes, ignored opcode), full
// stores, then random unit sets and noise, under changing register settings and
// idling patterns, each result checked against a typed value or a local predictor
// ----------------------------------------------------------------------------
module tb_av_startup_window_search_top;
    import avsws_pkg::*;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         DEPTH      = 256;
    localparam longint     T_MAX      = 64'sd140737488355327;
    localparam longint     T_MIN      = -64'sd140737488355328;
    localparam logic [46:0] MAX47     = {47{1'b1}};
    localparam int         SETTLE     = 40;
    localparam longint     LIMIT      = 3000000;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         vslot;
        logic [7:0]         aslot;
        logic signed [47:0] wstart;
        logic [9:0]         steps;
    } window_t;

    typedef struct {
        logic [1:0]         op;
        logic signed [47:0] st;
        logic [46:0]        du;
        logic signed [47:0] cv;
        bit                 key;
        bit                 typed;
        window_t            res;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [5:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    // predictor state
    longint  v_start [DEPTH];
    longint  v_cover [DEPTH];
    bit      v_key   [DEPTH];
    longint  a_start [DEPTH];
    longint  a_dur   [DEPTH];
    longint  a_cover [DEPTH];
    int      v_count;
    int      a_count;
    bit      lost;
    bit      cfg_key;
    bit      cfg_trim;
    longint  cfg_skew;
    longint  cfg_pre;
    longint  cfg_mtrim;

    window_t windows_due[$];
    int      errors;
    int      items_sent;
    int      runs_seen;
    int      status_seen [4];
    int      idle_pct;
    int      stall_pct;
    longint  cycles;
    row_t    dir_rows[$];

    av_startup_window_search_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic bit in_span(longint v);
        return v >= T_MIN && v <= T_MAX;
    endfunction

    // two-pointer window search over the loaded units
    function automatic void search_window(output logic [1:0] st, output int vs,
                                          output int as, output longint ws,
                                          output int steps);
        int     ac;
        longint lo, hi, vneed, astart, src, aend, need;
        ac = 0; vs = 0; as = 0; ws = 0; steps = 0;
        for (int vi = 0; vi < v_count; vi++) begin
            steps++;
            if (cfg_key && !v_key[vi]) continue;
            lo    = v_start[vi] - cfg_skew;
            hi    = v_start[vi] + cfg_skew;
            vneed = v_start[vi] + cfg_pre;
            if (!in_span(lo) || !in_span(hi) || !in_span(vneed)) begin
                st = ST_ARITH;
                return;
            end
            if (v_cover[vi] < vneed) continue;
            while (ac < a_count && a_start[ac] < lo) begin
                steps++;
                ac++;
            end
            while (ac < a_count && a_start[ac] <= hi) begin
                astart = a_start[ac];
                steps++;
                if (!cfg_trim && astart < v_start[vi]) begin
                    ac++;
                    continue;
                end
                src  = (cfg_trim && astart > v_start[vi]) ? astart : v_start[vi];
                aend = astart + a_dur[ac];
                need = src + cfg_pre;
                if (!in_span(aend) || !in_span(need)) begin
                    st = ST_ARITH;
                    return;
                end
                if (aend <= src) begin
                    ac++;
                    continue;
                end
                if (cfg_trim) begin
                    if (!in_span(src - astart)) begin
                        st = ST_ARITH;
                        return;
                    end
                    if (src - astart > cfg_mtrim) begin
                        ac++;
                        continue;
                    end
                end
                if (v_cover[vi] < need) break;
                if (a_cover[ac] >= need) begin
                    vs = vi; as = ac; ws = src;
                    st = ST_FOUND;
                    return;
                end
                ac++;
            end
        end
        st = ST_NONE;
    endfunction

    // apply one accepted word to the predictor, return its result if any
    function automatic bit predict_word(logic [1:0] op, logic signed [47:0] st,
                                        logic [46:0] du, logic signed [47:0] cv,
                                        bit key, output window_t w);
        logic [1:0] code;
        int         vs, as, steps;
        longint     ws;
        w = '0;
        case (op)
            OP_LOAD_VIDEO: begin
                if (v_count >= DEPTH) lost = 1'b1;
                else begin
                    v_start[v_count] = longint'(st);
                    v_cover[v_count] = longint'(cv);
                    v_key[v_count]   = key;
                    v_count++;
                end
                return 1'b0;
            end
            OP_LOAD_AUDIO: begin
                if (a_count >= DEPTH) lost = 1'b1;
                else begin
                    a_start[a_count] = longint'(st);
                    a_dur[a_count]   = longint'({17'd0, du});
                    a_cover[a_count] = longint'(cv);
                    a_count++;
                end
                return 1'b0;
            end
            OP_RUN: begin
                steps = 0; vs = 0; as = 0; ws = 0;
                if (lost) code = ST_CAPACITY;
                else search_window(code, vs, as, ws, steps);
                if (code != ST_FOUND) begin
                    vs = 0; as = 0; ws = 0;
                end
                w.status = code;
                w.vslot  = vs[7:0];
                w.aslot  = as[7:0];
                w.wstart = ws[47:0];
                w.steps  = steps > 1023 ? 10'd1023 : steps[9:0];
                v_count = 0;
                a_count = 0;
                lost    = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // result side: random stalls, check each word against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        window_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (windows_due.size() == 0) report("unexpected word", m_tdata[63:0], 64'(0));
            else begin
                w = windows_due.pop_front();
                runs_seen++;
                status_seen[m_tuser]++;
                if (m_tuser != w.status)
                    report("status", 64'(m_tuser), 64'(w.status));
                if (m_tdata[7:0] != w.vslot)
                    report("video_slot", 64'(m_tdata[7:0]), 64'(w.vslot));
                if (m_tdata[15:8] != w.aslot)
                    report("audio_slot", 64'(m_tdata[15:8]), 64'(w.aslot));
                if (m_tdata[63:16] != w.wstart)
                    report("window_start", 64'(m_tdata[63:16]), 64'(unsigned'(w.wstart)));
                if (m_tdata[73:64] != w.steps)
                    report("step_count", 64'(m_tdata[73:64]), 64'(w.steps));
                if (m_tdata[79:74] != 6'd0)
                    report("pad bits", 64'(m_tdata[79:74]), 64'(0));
            end
        end
    end

    // send one word; typed expectation replaces the predicted one when given
    task automatic send(logic [1:0] op, logic signed [47:0] st, logic [46:0] du,
                        logic signed [47:0] cv, bit key, bit typed = 0,
                        window_t typed_res = '0);
        window_t w;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {key, cv, du, st};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (predict_word(op, st, du, cv, key, w))
            windows_due.push_back(typed ? typed_res : w);
    endtask

    task automatic drain(int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (windows_due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic reg_write(int idx, logic [63:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 6'(8 * idx);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_KEY:   cfg_key   = val[0];
            CFG_TRIM:  cfg_trim  = val[0];
            CFG_SKEW:  cfg_skew  = longint'({17'd0, val[46:0]});
            CFG_PRE:   cfg_pre   = longint'({17'd0, val[46:0]});
            default:   cfg_mtrim = longint'({17'd0, val[46:0]});
        endcase
    endtask

    task automatic set_regs(bit key, bit trim, logic [46:0] skew, logic [46:0] pre,
                            logic [46:0] mtrim);
        reg_write(CFG_KEY, 64'(key));
        reg_write(CFG_TRIM, 64'(trim));
        reg_write(CFG_SKEW, 64'(skew));
        reg_write(CFG_PRE, 64'(pre));
        reg_write(CFG_MTRIM, 64'(mtrim));
        @(posedge aclk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic void add_row(logic [1:0] op, logic signed [47:0] st,
                                    logic [46:0] du, logic signed [47:0] cv, bit key,
                                    bit typed = 0, window_t res = '0);
        row_t r;
        r.op = op; r.st = st; r.du = du; r.cv = cv; r.key = key;
        r.typed = typed; r.res = res;
        dir_rows.push_back(r);
    endfunction

    // one well-formed set of units in ascending start order, then a run
    task automatic send_set(int nv, int na, logic signed [47:0] base);
        logic signed [47:0] t;
        t = base;
        for (int i = 0; i < nv; i++) begin
            t = t + $urandom_range(0, 20);
            send(OP_LOAD_VIDEO, t, 47'($urandom),
                 t + $signed(48'($urandom_range(0, 70))) - 48'sd5,
                 $urandom_range(0, 3) != 0);
        end
        t = base + $signed(48'($urandom_range(0, 40))) - 48'sd20;
        for (int i = 0; i < na; i++) begin
            t = t + $urandom_range(0, 20);
            send(OP_LOAD_AUDIO, t, 47'($urandom_range(0, 40)),
                 t + $signed(48'($urandom_range(0, 70))) - 48'sd5,
                 1'($urandom_range(0, 1)));
        end
        send(OP_RUN, rand48(), 47'(rand48()), rand48(), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic signed [47:0] pick_base();
        case ($urandom_range(0, 5))
            0:       return T_MAX[47:0] - 48'($urandom_range(0, 300));
            1:       return T_MIN[47:0] + 48'($urandom_range(0, 300));
            2:       return rand48();
            default: return $signed(48'($urandom_range(0, 2000))) - 48'sd1000;
        endcase
    endfunction

    function automatic logic [46:0] pick_span(bit wide);
        case ($urandom_range(0, wide ? 3 : 7))
            0:       return 47'd0;
            1:       return MAX47;
            2:       return 47'(rand48());
            default: return 47'($urandom_range(0, 40));
        endcase
    endfunction

    // stimulus
    initial begin
        window_t r;
        int      n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_LOAD_VIDEO;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors = 0; items_sent = 0; runs_seen = 0;
        idle_pct = 0; stall_pct = 0;
        v_count = 0; a_count = 0; lost = 1'b0;
        cfg_key = 1'b1; cfg_trim = 1'b0; cfg_skew = 0; cfg_pre = 0; cfg_mtrim = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, reset register values
        r = '0; r.status = ST_NONE;
        add_row(OP_RUN, 0, 0, 0, 0, 1, r);
        add_row(OP_IGNORED, rand48(), MAX47, rand48(), 1);
        add_row(OP_LOAD_VIDEO, 48'sd100, 0, 48'sd100, 1);
        add_row(OP_LOAD_AUDIO, 48'sd100, 47'd10, 48'sd100, 0);
        r = '0; r.status = ST_FOUND; r.wstart = 48'sd100; r.steps = 10'd2;
        add_row(OP_RUN, 0, 0, 0, 0, 1, r);
        add_row(OP_LOAD_VIDEO, T_MAX[47:0], 0, T_MAX[47:0], 1);
        add_row(OP_LOAD_AUDIO, T_MAX[47:0], 47'd1, T_MAX[47:0], 0);
        r = '0; r.status = ST_ARITH; r.steps = 10'd2;
        add_row(OP_RUN, 0, 0, 0, 0, 1, r);
        add_row(OP_LOAD_VIDEO, T_MIN[47:0], MAX47, T_MIN[47:0], 0);
        add_row(OP_LOAD_VIDEO, 0, 0, T_MAX[47:0], 1);
        add_row(OP_LOAD_AUDIO, T_MIN[47:0], MAX47, T_MIN[47:0], 1);
        add_row(OP_LOAD_AUDIO, 0, MAX47, T_MAX[47:0], 1);
        add_row(OP_RUN, -48'sd1, MAX47, -48'sd1, 1);
        add_row(OP_LOAD_VIDEO, -48'sd1, MAX47, -48'sd1, 1);
        add_row(OP_LOAD_AUDIO, -48'sd1, 0, -48'sd1, 1);
        add_row(OP_RUN, 0, 0, 0, 0);
        foreach (dir_rows[i])
            send(dir_rows[i].op, dir_rows[i].st, dir_rows[i].du, dir_rows[i].cv,
                 dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

        // full stores: one dropped video load, then one dropped audio load
        for (int i = 0; i <= DEPTH; i++) send(OP_LOAD_VIDEO, 48'(i), 0, 48'(i + 5), 1);
        send(OP_RUN, 0, 0, 0, 0);
        for (int i = 0; i <= DEPTH; i++) send(OP_LOAD_AUDIO, 48'(i), 47'd3, 48'(i + 5), 0);
        send(OP_RUN, 0, 0, 0, 0);
        drain(SETTLE);

        // random phases: register setting and idling pattern change together
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       set_regs(0, 0, 0, 0, 0);
                1:       set_regs(1, 1, MAX47, MAX47, MAX47);
                default: set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  pick_span(ph == 7), pick_span(ph == 7), pick_span(0));
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            n = items_sent + 80;
            while (items_sent < n) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any field values, ignored opcode, unsorted units
                    send(2'($urandom), rand48(), 47'(rand48()), rand48(),
                         1'($urandom_range(0, 1)));
                end else if ($urandom_range(0, 59) == 0) begin
                    send_set($urandom_range(20, 40), $urandom_range(20, 40), pick_base());
                end else begin
                    send_set($urandom_range(0, 8), $urandom_range(0, 8), pick_base());
                end
                if (ph == 3 && items_sent > n - 75 && items_sent < n - 60) drain(0);
            end
            drain(SETTLE);
        end

        $display("%0d words sent, %0d results checked over 8 register settings",
                 items_sent, runs_seen);
        $display("found %0d, none %0d, overflow %0d, store full %0d",
                 status_seen[ST_FOUND], status_seen[ST_NONE], status_seen[ST_ARITH],
                 status_seen[ST_CAPACITY]);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

>>> av_startup_window_search_top.f
+incdir+rtl
rtl/avsws_pkg.sv
rtl/avsws_datapath.sv
rtl/avsws_ctrl.sv
rtl/av_startup_window_search_top.sv
bench/tb_av_startup_window_search_top.sv
